// ----- rtl/cdta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date and time adder package
// Widths, calendar constants, request and status codes, month tables and the
// request and response types of the shared floor divider.
// ----------------------------------------------------------------------------
package cdta_pkg;

  localparam int YEAR_BITS = 16;
  localparam int DIV_W     = 34;
  localparam int YW_W      = DIV_W + 1;
  localparam int REM_W     = 9;
  localparam int BASE_W    = 9;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [REM_W-1:0] SECS_PER_MIN    = 9'd60;
  localparam logic [REM_W-1:0] MINS_PER_HOUR   = 9'd60;
  localparam logic [REM_W-1:0] HOURS_PER_DAY   = 9'd24;
  localparam logic [REM_W-1:0] DAYS_PER_YEAR   = 9'd365;
  localparam logic [REM_W-1:0] MONTHS_PER_YEAR = 9'd12;
  localparam logic [3:0]       LAST_MONTH_IDX  = 4'd11;

  localparam logic [2:0] REQ_LOAD    = 3'd0;
  localparam logic [2:0] REQ_SECONDS = 3'd1;
  localparam logic [2:0] REQ_MINUTES = 3'd2;
  localparam logic [2:0] REQ_HOURS   = 3'd3;
  localparam logic [2:0] REQ_DAYS    = 3'd4;
  localparam logic [2:0] REQ_MONTHS  = 3'd5;
  localparam logic [2:0] REQ_YEARS   = 3'd6;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_LOAD   = 2'd1;
  localparam logic [1:0] ST_YEAR_RANGE = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [REM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] len;
    case (idx)
      4'd1:    len = 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [BASE_W-1:0] month_start(input logic [3:0] idx);
    logic [BASE_W-1:0] days;
    case (idx)
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd59;
      4'd3:    days = 9'd90;
      4'd4:    days = 9'd120;
      4'd5:    days = 9'd151;
      4'd6:    days = 9'd181;
      4'd7:    days = 9'd212;
      4'd8:    days = 9'd243;
      4'd9:    days = 9'd273;
      4'd10:   days = 9'd304;
      4'd11:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

// ----- rtl/calendar_date_time_adder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar date and time adder
// Holds a date and time of day and applies load and signed add requests.
// ----------------------------------------------------------------------------
// The input channel carries one request per transfer: a load of all fields, or
// a signed add of seconds, minutes, hours, days, months or years. Every request
// yields exactly one transfer on the result channel with the held date and
// time after the request and a status code.
// A request is taken only while the sequencer is idle. Its carries run through
// one shared floor divider, seconds to minutes to hours to days, followed by a
// walk through the months. A load or an ignored request goes straight to the
// final step that fills the output register; a year add first passes the year
// check, a month add one division and the check, a day add one division, the
// walk and the check, and a second add four divisions, the walk and the check.
// The output register lets a new request start while a result still waits;
// when the receiver stalls, the finished result holds until it is taken and
// the next request waits in its final step.
// After reset the block holds 00:00:00 on day 1 of month 1 of year 1 and no
// result is pending.
// ----------------------------------------------------------------------------
module calendar_date_time_adder (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_req_type,
  input  logic signed [31:0]             in_amount,
  input  logic [5:0]                     in_load_second,
  input  logic [5:0]                     in_load_minute,
  input  logic [4:0]                     in_load_hour,
  input  logic [4:0]                     in_load_day,
  input  logic [3:0]                     in_load_month,
  input  logic [cdta_pkg::YEAR_BITS-1:0] in_load_year,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [5:0]                     out_cur_second,
  output logic [5:0]                     out_cur_minute,
  output logic [4:0]                     out_cur_hour,
  output logic [4:0]                     out_cur_day,
  output logic [3:0]                     out_cur_month,
  output logic [cdta_pkg::YEAR_BITS-1:0] out_cur_year,
  output logic [1:0]                     out_status
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SEC   = 9'b000000010,
    S_MIN   = 9'b000000100,
    S_HOUR  = 9'b000001000,
    S_DAY   = 9'b000010000,
    S_MON   = 9'b000100000,
    S_WALK  = 9'b001000000,
    S_CHECK = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                           st_r, st_nxt;
  logic                             issued_r, issued_nxt;
  logic [cdta_pkg::DIV_W-1:0]       carry_r, carry_nxt;
  logic [cdta_pkg::YW_W-1:0]        yw_r, yw_nxt;
  logic [cdta_pkg::BASE_W-1:0]      doy_r, doy_nxt;
  logic [3:0]                       mi_r, mi_nxt;
  logic [1:0]                       status_r, status_nxt;

  logic [5:0]                       w_sec_r, w_sec_nxt;
  logic [5:0]                       w_min_r, w_min_nxt;
  logic [4:0]                       w_hour_r, w_hour_nxt;
  logic [4:0]                       w_day_r, w_day_nxt;
  logic [3:0]                       w_month_r, w_month_nxt;

  logic [5:0]                       sec_r, sec_nxt;
  logic [5:0]                       min_r, min_nxt;
  logic [4:0]                       hour_r, hour_nxt;
  logic [4:0]                       day_r, day_nxt;
  logic [3:0]                       month_r, month_nxt;
  logic [cdta_pkg::YEAR_BITS-1:0]   year_r, year_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [5:0]                       o_sec_r, o_sec_nxt;
  logic [5:0]                       o_min_r, o_min_nxt;
  logic [4:0]                       o_hour_r, o_hour_nxt;
  logic [4:0]                       o_day_r, o_day_nxt;
  logic [3:0]                       o_month_r, o_month_nxt;
  logic [cdta_pkg::YEAR_BITS-1:0]   o_year_r, o_year_nxt;
  logic [1:0]                       o_status_r, o_status_nxt;

  cdta_pkg::div_req_t               div_req;
  cdta_pkg::div_rsp_t               div_rsp;

  logic                             in_xfer;
  logic                             load_ok;
  logic [cdta_pkg::BASE_W-1:0]      base;
  logic [cdta_pkg::YW_W-1:0]        year_ext;
  logic [cdta_pkg::YW_W-1:0]        quot_ext;
  logic [cdta_pkg::YW_W-1:0]        amt_ext;
  logic                             year_ok;
  logic [4:0]                       walk_len;
  logic [4:0]                       clamp_len;

  cdta_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_stall = (st_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign load_ok = (in_load_second < 6'd60) && (in_load_minute < 6'd60) &&
                   (in_load_hour < 5'd24) && (in_load_month >= 4'd1) &&
                   (in_load_month <= 4'd12) && (in_load_day >= 5'd1) &&
                   (in_load_year != '0) &&
                   (in_load_day <= cdta_pkg::month_len(in_load_month - 4'd1));

  assign year_ext  = {{(cdta_pkg::YW_W - cdta_pkg::YEAR_BITS){1'b0}}, year_r};
  assign quot_ext  = {div_rsp.quot[cdta_pkg::DIV_W-1], div_rsp.quot};
  assign amt_ext   = {{(cdta_pkg::YW_W - 32){in_amount[31]}}, in_amount};
  assign year_ok   = !yw_r[cdta_pkg::YW_W-1] && (yw_r != '0) &&
                     (yw_r[cdta_pkg::YW_W-2:cdta_pkg::YEAR_BITS] == '0);
  assign walk_len  = cdta_pkg::month_len(mi_r);
  assign clamp_len = cdta_pkg::month_len(div_rsp.rem[3:0]);

  always_comb begin
    base            = '0;
    div_req.divisor = cdta_pkg::SECS_PER_MIN;
    case (st_r)
      S_SEC: begin
        base            = cdta_pkg::BASE_W'(w_sec_r);
        div_req.divisor = cdta_pkg::SECS_PER_MIN;
      end
      S_MIN: begin
        base            = cdta_pkg::BASE_W'(w_min_r);
        div_req.divisor = cdta_pkg::MINS_PER_HOUR;
      end
      S_HOUR: begin
        base            = cdta_pkg::BASE_W'(w_hour_r);
        div_req.divisor = cdta_pkg::HOURS_PER_DAY;
      end
      S_DAY: begin
        base            = cdta_pkg::month_start(w_month_r - 4'd1) +
                          cdta_pkg::BASE_W'(w_day_r) - 1'b1;
        div_req.divisor = cdta_pkg::DAYS_PER_YEAR;
      end
      S_MON: begin
        base            = cdta_pkg::BASE_W'(w_month_r - 4'd1);
        div_req.divisor = cdta_pkg::MONTHS_PER_YEAR;
      end
      default: begin
        base            = '0;
        div_req.divisor = cdta_pkg::SECS_PER_MIN;
      end
    endcase
    div_req.dividend = {{(cdta_pkg::DIV_W - cdta_pkg::BASE_W){1'b0}}, base} + carry_r;
    div_req.start    = ((st_r == S_SEC) || (st_r == S_MIN) || (st_r == S_HOUR) ||
                        (st_r == S_DAY) || (st_r == S_MON)) && !issued_r;
  end

  always_comb begin
    st_nxt        = st_r;
    issued_nxt    = issued_r;
    carry_nxt     = carry_r;
    yw_nxt        = yw_r;
    doy_nxt       = doy_r;
    mi_nxt        = mi_r;
    status_nxt    = status_r;
    w_sec_nxt     = w_sec_r;
    w_min_nxt     = w_min_r;
    w_hour_nxt    = w_hour_r;
    w_day_nxt     = w_day_r;
    w_month_nxt   = w_month_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hour_nxt      = hour_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    out_valid_nxt = out_valid_r && out_stall;
    o_sec_nxt     = o_sec_r;
    o_min_nxt     = o_min_r;
    o_hour_nxt    = o_hour_r;
    o_day_nxt     = o_day_r;
    o_month_nxt   = o_month_r;
    o_year_nxt    = o_year_r;
    o_status_nxt  = o_status_r;

    if (div_req.start) begin
      issued_nxt = 1'b1;
    end

    case (st_r)
      S_IDLE: begin
        if (in_xfer) begin
          w_sec_nxt   = sec_r;
          w_min_nxt   = min_r;
          w_hour_nxt  = hour_r;
          w_day_nxt   = day_r;
          w_month_nxt = month_r;
          carry_nxt   = amt_ext[cdta_pkg::DIV_W-1:0];
          status_nxt  = cdta_pkg::ST_OK;
          case (in_req_type)
            cdta_pkg::REQ_LOAD: begin
              if (load_ok) begin
                sec_nxt   = in_load_second;
                min_nxt   = in_load_minute;
                hour_nxt  = in_load_hour;
                day_nxt   = in_load_day;
                month_nxt = in_load_month;
                year_nxt  = in_load_year;
              end else begin
                status_nxt = cdta_pkg::ST_BAD_LOAD;
              end
              st_nxt = S_DONE;
            end
            cdta_pkg::REQ_SECONDS: st_nxt = S_SEC;
            cdta_pkg::REQ_MINUTES: st_nxt = S_MIN;
            cdta_pkg::REQ_HOURS:   st_nxt = S_HOUR;
            cdta_pkg::REQ_DAYS:    st_nxt = S_DAY;
            cdta_pkg::REQ_MONTHS:  st_nxt = S_MON;
            cdta_pkg::REQ_YEARS: begin
              yw_nxt = year_ext + amt_ext;
              st_nxt = S_CHECK;
            end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_SEC: begin
        if (div_rsp.done) begin
          w_sec_nxt  = div_rsp.rem[5:0];
          carry_nxt  = div_rsp.quot;
          issued_nxt = 1'b0;
          st_nxt     = S_MIN;
        end
      end
      S_MIN: begin
        if (div_rsp.done) begin
          w_min_nxt  = div_rsp.rem[5:0];
          carry_nxt  = div_rsp.quot;
          issued_nxt = 1'b0;
          st_nxt     = S_HOUR;
        end
      end
      S_HOUR: begin
        if (div_rsp.done) begin
          w_hour_nxt = div_rsp.rem[4:0];
          carry_nxt  = div_rsp.quot;
          issued_nxt = 1'b0;
          st_nxt     = S_DAY;
        end
      end
      S_DAY: begin
        if (div_rsp.done) begin
          doy_nxt    = div_rsp.rem;
          yw_nxt     = year_ext + quot_ext;
          mi_nxt     = '0;
          issued_nxt = 1'b0;
          st_nxt     = S_WALK;
        end
      end
      S_MON: begin
        if (div_rsp.done) begin
          w_month_nxt = div_rsp.rem[3:0] + 4'd1;
          yw_nxt      = year_ext + quot_ext;
          if (w_day_r > clamp_len) begin
            w_day_nxt = clamp_len;
          end
          issued_nxt  = 1'b0;
          st_nxt      = S_CHECK;
        end
      end
      S_WALK: begin
        if ((mi_r < cdta_pkg::LAST_MONTH_IDX) &&
            (doy_r >= cdta_pkg::BASE_W'(walk_len))) begin
          doy_nxt = doy_r - cdta_pkg::BASE_W'(walk_len);
          mi_nxt  = mi_r + 4'd1;
        end else begin
          w_month_nxt = mi_r + 4'd1;
          w_day_nxt   = doy_r[4:0] + 5'd1;
          st_nxt      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (year_ok) begin
          sec_nxt   = w_sec_r;
          min_nxt   = w_min_r;
          hour_nxt  = w_hour_r;
          day_nxt   = w_day_r;
          month_nxt = w_month_r;
          year_nxt  = yw_r[cdta_pkg::YEAR_BITS-1:0];
        end else begin
          status_nxt = cdta_pkg::ST_YEAR_RANGE;
        end
        st_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_sec_nxt     = sec_r;
          o_min_nxt     = min_r;
          o_hour_nxt    = hour_r;
          o_day_nxt     = day_r;
          o_month_nxt   = month_r;
          o_year_nxt    = year_r;
          o_status_nxt  = status_r;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sec_r       <= 6'd0;
      min_r       <= 6'd0;
      hour_r      <= 5'd0;
      day_r       <= 5'd1;
      month_r     <= 4'd1;
      year_r      <= cdta_pkg::YEAR_BITS'(1);
    end else begin
      st_r        <= st_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      sec_r       <= sec_nxt;
      min_r       <= min_nxt;
      hour_r      <= hour_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r    <= carry_nxt;
    yw_r       <= yw_nxt;
    doy_r      <= doy_nxt;
    mi_r       <= mi_nxt;
    status_r   <= status_nxt;
    w_sec_r    <= w_sec_nxt;
    w_min_r    <= w_min_nxt;
    w_hour_r   <= w_hour_nxt;
    w_day_r    <= w_day_nxt;
    w_month_r  <= w_month_nxt;
    o_sec_r    <= o_sec_nxt;
    o_min_r    <= o_min_nxt;
    o_hour_r   <= o_hour_nxt;
    o_day_r    <= o_day_nxt;
    o_month_r  <= o_month_nxt;
    o_year_r   <= o_year_nxt;
    o_status_r <= o_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_cur_second = o_sec_r;
  assign out_cur_minute = o_min_r;
  assign out_cur_hour   = o_hour_r;
  assign out_cur_day    = o_day_r;
  assign out_cur_month  = o_month_r;
  assign out_cur_year   = o_year_r;
  assign out_status     = o_status_r;

endmodule

// ----- rtl/cdta_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared floor divider
// Divides a signed two's complement dividend by a small positive divisor,
// two quotient bits per cycle, and rounds the quotient towards minus infinity
// so that the remainder always lies between zero and the divisor.
// ----------------------------------------------------------------------------
module cdta_div (
  input  logic               clk,
  input  logic               rst_n,
  input  cdta_pkg::div_req_t req_i,
  output cdta_pkg::div_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_RUN  = 3'b010,
    D_FIX  = 3'b100
  } dstate_t;

  dstate_t                       st_r, st_nxt;
  logic                          neg_r, neg_nxt;
  logic [cdta_pkg::DIV_W-1:0]    mag_r, mag_nxt;
  logic [cdta_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [cdta_pkg::REM_W-1:0]    dsr_r, dsr_nxt;
  logic [cdta_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          done_r, done_nxt;
  logic [cdta_pkg::DIV_W-1:0]    quot_r, quot_nxt;
  logic [cdta_pkg::REM_W-1:0]    remq_r, remq_nxt;

  logic [cdta_pkg::REM_W:0]      t1, t2;
  logic                          ge1, ge2;
  logic [cdta_pkg::REM_W-1:0]    r1, r2;
  logic [cdta_pkg::DIV_W-1:0]    mag_abs;

  always_comb begin
    t1  = {rem_r, mag_r[cdta_pkg::DIV_W-1]};
    ge1 = (t1 >= {1'b0, dsr_r});
    r1  = ge1 ? cdta_pkg::REM_W'(t1 - {1'b0, dsr_r}) : t1[cdta_pkg::REM_W-1:0];
    t2  = {r1, mag_r[cdta_pkg::DIV_W-2]};
    ge2 = (t2 >= {1'b0, dsr_r});
    r2  = ge2 ? cdta_pkg::REM_W'(t2 - {1'b0, dsr_r}) : t2[cdta_pkg::REM_W-1:0];
    mag_abs = req_i.dividend[cdta_pkg::DIV_W-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;

    st_nxt   = st_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    quot_nxt = quot_r;
    remq_nxt = remq_r;

    case (st_r)
      D_IDLE: begin
        if (req_i.start) begin
          neg_nxt = req_i.dividend[cdta_pkg::DIV_W-1];
          mag_nxt = mag_abs;
          rem_nxt = '0;
          dsr_nxt = req_i.divisor;
          cnt_nxt = '0;
          st_nxt  = D_RUN;
        end
      end
      D_RUN: begin
        mag_nxt = {mag_r[cdta_pkg::DIV_W-3:0], ge1, ge2};
        rem_nxt = r2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == cdta_pkg::CNT_W'(cdta_pkg::DIV_STEPS - 1)) begin
          st_nxt = D_FIX;
        end
      end
      D_FIX: begin
        // A negative dividend with a remainder steps the quotient down by one.
        if (neg_r && (rem_r != '0)) begin
          quot_nxt = ~mag_r;
          remq_nxt = dsr_r - rem_r;
        end else if (neg_r) begin
          quot_nxt = ~mag_r + 1'b1;
          remq_nxt = '0;
        end else begin
          quot_nxt = mag_r;
          remq_nxt = rem_r;
        end
        done_nxt = 1'b1;
        st_nxt   = D_IDLE;
      end
      default: begin
        st_nxt = D_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    quot_r <= quot_nxt;
    remq_r <= remq_nxt;
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quot = quot_r;
  assign rsp_o.rem  = remq_r;

endmodule
